FILE: rtl/tcw_pkg.sv
// shared types and constants of the text console writer
// no dependencies; every other file but tcw_ram imports this package
`default_nettype none

package tcw_pkg;

  // screen geometry
  localparam int ROWS       = 25;
  localparam int COLS       = 80;
  localparam int CELLS      = ROWS * COLS;
  localparam int MOVE_CELLS = (ROWS - 1) * COLS;

  // widths, most of them derived from the geometry
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int COL_W  = $clog2(COLS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int POS_W  = 11;
  localparam int WIDE_W = (ADDR_W > POS_W) ? ADDR_W : POS_W;
  localparam int CELL_W = 16;

  // command queue between front and back, power of two
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] NL_CODE        = 8'd10;
  localparam logic [7:0] BS_CODE        = 8'd8;
  localparam logic [7:0] BLANK_CHAR     = 8'h20;
  localparam logic [7:0] TEXT_ATTR_RST  = 8'h6F;
  localparam logic [7:0] BLANK_ATTR_RST = 8'h0F;

  typedef enum logic [2:0] {
    CMD_PUT_CHAR    = 3'd0,
    CMD_PUT_COLORED = 3'd1,
    CMD_WRITE_AT    = 3'd2,
    CMD_CLEAR       = 3'd3,
    CMD_READ_CELL   = 3'd4
  } cmd_e;

  typedef enum logic [0:0] {
    REG_TEXT_ATTR  = 1'b0,
    REG_BLANK_ATTR = 1'b1
  } reg_idx_e;

  localparam int REG_IDX_W = 1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_CLEAR,
    OP_READ
  } op_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SCROLL,
    BK_BLANK
  } bk_state_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [4:0] target_row;
    logic [6:0] target_col;
  } item_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic        did_scroll;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } result_t;

  // one classified command for the back end
  typedef struct packed {
    op_kind_e            kind;
    logic                scroll;
    logic [ADDR_W-1:0]   addr;
    logic [CELL_W-1:0]   cell_word;
    result_t             res;
  } op_t;

endpackage

`default_nettype wire

FILE: rtl/text_console_writer.sv
// text console writer top level: config registers, front end, op queue, back end
// depends on tcw_pkg, tcw_front, tcw_queue, tcw_back (and tcw_ram below it)
//
// usage
//   item channel (item_valid / item_stall / item) carries one command each transfer;
//   result channel (result_valid / result_stall / result) returns exactly one result
//   per command, in order. cfg_we / cfg_index / cfg_data write text_attr (index 0)
//   or blank_attr (index 1); write only while the block is idle.
// timing
//   a cell write, cursor move or ignored command passes from its transfer
//   through the op queue into the result register; such commands stream at
//   one per cycle while no long op or result stall holds the back end; the
//   front end and the back end are parted by a two entry op queue.
//   read_cell adds a registered read of the cell store; clear sweeps every
//   cell through the one write port. a scroll copies each row up through the
//   store's read and write ports, one cell per cycle, then blanks the bottom
//   row after the print; the item side stalls once the queue fills.
// reset
//   rst clears cursor, queue, back end state and result_valid; the cell
//   store is not swept and holds nothing usable until the first clear.
// receiver stall
//   a waiting result holds; the back end starts no new op until the result
//   register is free, and the front end keeps taking items until the queue fills.
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire item_t                item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output result_t                   result,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  logic [7:0] text_attr;
  logic [7:0] blank_attr;

  // front to queue
  logic push;
  op_t  push_op;
  logic q_full;

  // queue to back
  logic q_valid;
  logic pop;
  op_t  head;

  // configuration registers, plain writes with no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr  <= TEXT_ATTR_RST;
      blank_attr <= BLANK_ATTR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEXT_ATTR:  text_attr  <= cfg_data;
        REG_BLANK_ATTR: blank_attr <= cfg_data;
      endcase
    end
  end

  // front end owns the cursor, so cursor_pos and echo are known at transfer time
  tcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .text_attr  (text_attr),
    .q_full     (q_full),
    .push       (push),
    .op         (push_op)
  );

  tcw_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .head    (head)
  );

  // back end owns the cell store and the result register
  tcw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .head         (head),
    .pop          (pop),
    .blank_attr   (blank_attr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

FILE: rtl/tcw_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcw_front.sv
// front end: accepts items, keeps the cursor and classifies each item into a back end op
// depends on tcw_pkg
`default_nettype none

module tcw_front
  import tcw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_stall,
  input  wire item_t item,
  input  wire logic [7:0] text_attr,
  input  wire logic  q_full,
  output logic       push,
  output op_t        op
);

  logic [ROW_W-1:0]  cur_row, row_next;
  logic [COL_W-1:0]  cur_col, col_next;
  logic [ADDR_W-1:0] cur_addr, tgt_addr, pos_addr;
  logic [WIDE_W-1:0] pos_wide;
  logic              tgt_ok;
  logic              last_col;
  logic              is_put;

  assign item_stall = q_full;
  assign push       = item_valid && !q_full;

  assign cur_addr = ADDR_W'(cur_row) * ADDR_W'(COLS) + ADDR_W'(cur_col);
  assign tgt_addr = ADDR_W'(item.target_row) * ADDR_W'(COLS) + ADDR_W'(item.target_col);
  assign tgt_ok   = (int'(item.target_row) < ROWS) && (int'(item.target_col) < COLS);
  assign last_col = (cur_col == COL_W'(COLS - 1));
  assign is_put   = (item.cmd == CMD_PUT_CHAR) || (item.cmd == CMD_PUT_COLORED);

  always_comb begin
    row_next = cur_row;
    col_next = cur_col;
    op       = '0;
    op.kind  = OP_NONE;
    op.addr  = cur_addr;
    unique case (item.cmd)
      CMD_PUT_CHAR: begin
        if (item.char_code == NL_CODE) begin
          op.res.echo_valid = 1'b1;
          op.res.echo_byte  = item.char_code;
          row_next          = cur_row + ROW_W'(1);
          col_next          = '0;
        end else if (item.char_code == BS_CODE) begin
          if (cur_col != '0) begin
            col_next = cur_col - COL_W'(1);
          end else if (cur_row != '0) begin
            row_next = cur_row - ROW_W'(1);
            col_next = COL_W'(COLS - 1);
          end
        end else begin
          op.kind           = OP_WRITE;
          op.cell_word      = {text_attr, item.char_code};
          op.res.echo_valid = 1'b1;
          op.res.echo_byte  = item.char_code;
          if (last_col) begin
            col_next = '0;
            row_next = cur_row + ROW_W'(1);
          end else begin
            col_next = cur_col + COL_W'(1);
          end
        end
      end
      CMD_PUT_COLORED: begin
        if (item.char_code == NL_CODE) begin
          row_next = cur_row + ROW_W'(1);
          col_next = '0;
        end else begin
          op.kind      = OP_WRITE;
          op.cell_word = {item.attribute, item.char_code};
          if (last_col) begin
            col_next = '0;
            row_next = cur_row + ROW_W'(1);
          end else begin
            col_next = cur_col + COL_W'(1);
          end
        end
      end
      CMD_WRITE_AT: begin
        if (tgt_ok) begin
          op.kind      = OP_WRITE;
          op.addr      = tgt_addr;
          op.cell_word = {text_attr, item.char_code};
        end
      end
      CMD_CLEAR: begin
        op.kind  = OP_CLEAR;
        row_next = '0;
        col_next = '0;
      end
      CMD_READ_CELL: begin
        if (tgt_ok) begin
          op.kind = OP_READ;
          op.addr = tgt_addr;
        end
      end
      default: ;
    endcase

    // running past the last row scrolls and keeps the cursor on the bottom row
    if (is_put && (int'(row_next) >= ROWS)) begin
      row_next          = ROW_W'(ROWS - 1);
      op.scroll         = 1'b1;
      op.res.did_scroll = 1'b1;
    end

    pos_addr          = ADDR_W'(row_next) * ADDR_W'(COLS) + ADDR_W'(col_next);
    pos_wide          = WIDE_W'(pos_addr);
    op.res.cursor_pos = pos_wide[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
    end else if (push) begin
      cur_row <= row_next;
      cur_col <= col_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcw_queue.sv
// short op queue between front and back end
// depends on tcw_pkg
`default_nettype none

module tcw_queue
  import tcw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire op_t  push_op,
  output logic      full,
  input  wire logic pop,
  output logic      q_valid,
  output op_t       head
);

  localparam int Q_AW = $clog2(QUEUE_DEPTH);
  localparam int Q_CW = $clog2(QUEUE_DEPTH + 1);

  op_t              entries [QUEUE_DEPTH];
  logic [Q_AW-1:0]  wr_ptr, rd_ptr;
  logic [Q_CW-1:0]  count;

  assign full    = (count == Q_CW'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CW'(1);
      end else if (pop && !push) begin
        count <= count - Q_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcw_back.sv
// back end: carries out ops on the cell store (write, read, scroll copy, blank sweep)
// depends on tcw_pkg and tcw_ram
`default_nettype none

module tcw_back
  import tcw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_valid,
  input  wire op_t       head,
  output logic           pop,
  input  wire logic [7:0] blank_attr,
  output logic           result_valid,
  input  wire logic      result_stall,
  output result_t        result
);

  bk_state_e          state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  op_t                op_reg;
  logic               out_free;
  logic               load;
  result_t            load_data;
  logic               we, re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [CELL_W-1:0]  wdata, rdata;

  assign out_free = !result_valid || !result_stall;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          cnt_next = '0;
          unique case (head.kind)
            OP_CLEAR: state_next = BK_BLANK;
            OP_READ:  state_next = BK_READ;
            default:  state_next = head.scroll ? BK_SCROLL : BK_IDLE;
          endcase
        end
      end
      BK_READ: state_next = BK_IDLE;
      BK_SCROLL: begin
        if (cnt == CNT_W'(MOVE_CELLS)) begin
          state_next = BK_BLANK;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      BK_BLANK: begin
        if (cnt == CNT_W'(CELLS - 1)) begin
          state_next = BK_IDLE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop       = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = head.addr;
    wdata     = head.cell_word;
    raddr     = head.addr;
    load      = 1'b0;
    load_data = op_reg.res;
    unique case (state)
      BK_IDLE: begin
        pop       = q_valid && out_free;
        we        = pop && (head.kind == OP_WRITE);
        re        = pop && (head.kind == OP_READ);
        load      = pop && !head.scroll && ((head.kind == OP_NONE) || (head.kind == OP_WRITE));
        load_data = head.res;
      end
      BK_READ: begin
        load                = 1'b1;
        load_data.cell_char = rdata[7:0];
        load_data.cell_attr = rdata[15:8];
      end
      BK_SCROLL: begin
        re    = (cnt < CNT_W'(MOVE_CELLS));
        raddr = ADDR_W'(cnt + CNT_W'(COLS));
        we    = (cnt != '0);
        waddr = ADDR_W'(cnt - CNT_W'(1));
        wdata = rdata;
      end
      BK_BLANK: begin
        we    = 1'b1;
        waddr = ADDR_W'(cnt);
        wdata = {blank_attr, BLANK_CHAR};
        load  = (cnt == CNT_W'(CELLS - 1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_reg <= head;
    end
    if (load) begin
      result <= load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcw_checker.sv
// port level checks of the text console writer, bound to the top level
// depends on tcw_pkg and text_console_writer
`default_nettype none

module tcw_checker
  import tcw_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    result_valid,
  input wire logic    result_stall,
  input wire result_t result
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // cursor stays on screen
  a_cursor: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (CELLS > 2047) || (int'(result.cursor_pos) < CELLS))
    else $error("cursor position off screen");

  // no echo means a zero echo byte
  a_echo_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.echo_valid |-> result.echo_byte == 8'd0)
    else $error("echo byte set without echo");

  // an echoing print never reports cell contents
  a_echo_no_cell: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.echo_valid |-> result.cell_char == 8'd0 && result.cell_attr == 8'd0)
    else $error("cell fields set on an echoed print");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
